// ===== rtl/core/csvp_pkg.sv =====
// Shared types, limits and codes for the CSV record field parser.
`timescale 1ns / 1ps

package csvp_pkg;

    // Line and field length limits (each limit counts the terminator slot)
    localparam int LINE_MAX        = 1024;
    localparam int NAME_MAX        = 64;
    localparam int KEY_MAX         = 64;
    localparam int NUMBER_TEXT_MAX = 64;

    localparam int LINE_LEN_W  = $clog2(LINE_MAX + 1);
    localparam int MAX_RESULTS = 5;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int FIELD_MAX   = 4;

    localparam logic [LINE_LEN_W:0] LINE_LIM = (LINE_LEN_W + 1)'(LINE_MAX);
    localparam logic [8:0]          NAME_LIM = 9'(NAME_MAX);
    localparam logic [8:0]          KEY_LIM  = 9'(KEY_MAX);
    localparam logic [8:0]          NUM_LIM  = 9'(NUMBER_TEXT_MAX);

    localparam logic [31:0] MAG_CAP = 32'h8000_0000;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Field slots
    localparam logic [1:0] SLOT_NAME     = 2'd0;
    localparam logic [1:0] SLOT_KEY_TYPE = 2'd1;
    localparam logic [1:0] SLOT_KEY      = 2'd2;
    localparam logic [1:0] SLOT_COUNT    = 2'd3;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_PLAIN,
        PH_QUOTED,
        PH_QSEEN,
        PH_AFTER,
        PH_DONE
    } scan_phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_STR_END,
        KIND_NUM_END
    } out_kind_t;

    typedef struct packed {
        logic [1:0]  pos;
        scan_phase_t phase;
        logic [7:0]  flen;
        logic [31:0] acc;
        logic        neg;
        logic        digits_done;
        logic        started;
        logic        key_num;
    } parse_state_t;

    typedef struct packed {
        out_kind_t   kind;
        logic [1:0]  slot;
        logic [7:0]  ch;
        logic [31:0] num;
        logic        last;
    } result_t;

endpackage

// ===== rtl/core/csv_record_field_parser.sv =====
// Top level: byte-stream CSV record splitter with per-byte result buffer.
// Each byte passes the input register, then its results are held in the result buffer.
// Throughput: one byte per cycle while each byte yields at most one result and m_tready is
// high; a byte that yields several results (up to 5, at a field end or line end) holds the
// input until the single output port has drained the result buffer.
// Reset: rst_n is asynchronous, active low; it clears the parser state and empties both stages.
`timescale 1ns / 1ps

module csv_record_field_parser
    import csvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] char_value, [39:8] number_value
    output logic [3:0]  m_tuser,   // [1:0] out_kind, [3:2] field_slot
    output logic        m_tlast    // last_of_record
);

    logic                  in_valid_reg;
    logic [7:0]            char_reg;
    logic                  eol_reg;
    parse_state_t          st_reg;
    parse_state_t          st_next;
    logic [LINE_LEN_W-1:0] line_reg;
    logic [LINE_LEN_W-1:0] line_next;
    result_t               res_reg [MAX_RESULTS];
    result_t               res_next [MAX_RESULTS];
    logic [RES_CNT_W-1:0]  res_cnt_reg;
    logic [RES_CNT_W-1:0]  res_cnt_next;
    logic [RES_CNT_W-1:0]  res_idx_reg;
    logic                  buf_busy;
    logic                  out_fire;
    logic                  buf_free;
    logic                  stage_move;
    result_t               cur_res;

    function automatic logic slot_str(parse_state_t s);
        return (s.pos == SLOT_NAME) || ((s.pos == SLOT_KEY) && !s.key_num);
    endfunction

    function automatic logic [31:0] end_value(parse_state_t s);
        logic [31:0] v;
        if (s.neg)
        begin
            v = 32'd0 - s.acc;
        end
        else if (s.acc > MAG_CAP - 32'd1)
        begin
            v = MAG_CAP - 32'd1;
        end
        else
        begin
            v = s.acc;
        end
        return v;
    endfunction

    function automatic result_t end_result(parse_state_t s);
        result_t r;
        r.kind = slot_str(s) ? KIND_STR_END : KIND_NUM_END;
        r.slot = s.pos;
        r.ch   = 8'd0;
        r.num  = slot_str(s) ? 32'd0 : end_value(s);
        r.last = (s.pos == SLOT_COUNT);
        return r;
    endfunction

    function automatic parse_state_t clear_field(parse_state_t s);
        parse_state_t t;
        t             = s;
        t.flen        = 8'd0;
        t.acc         = 32'd0;
        t.neg         = 1'b0;
        t.digits_done = 1'b0;
        t.started     = 1'b0;
        return t;
    endfunction

    function automatic parse_state_t end_state(parse_state_t s);
        parse_state_t t;
        t = s;
        if (!slot_str(s) && (s.pos == SLOT_KEY_TYPE))
        begin
            t.key_num = (end_value(s) == 32'd0);
        end
        t = clear_field(t);
        if (s.pos == SLOT_COUNT)
        begin
            t.phase = PH_DONE;
        end
        else
        begin
            t.pos   = s.pos + 2'd1;
            t.phase = PH_SKIP;
        end
        return t;
    endfunction

    function automatic parse_state_t number_byte(parse_state_t s, logic [7:0] c);
        parse_state_t t;
        logic [35:0]  prod;
        logic         space;
        t     = s;
        space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        prod  = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0}
              + {32'd0, 4'(c - CH_ZERO)};
        if (({1'b0, s.flen} + 9'd1) < NUM_LIM)
        begin
            t.flen = s.flen + 8'd1;
            if (!s.digits_done)
            begin
                if (!s.started && space)
                begin
                    t.started = 1'b0;
                end
                else if (!s.started && (c == CH_MINUS))
                begin
                    t.started = 1'b1;
                    t.neg     = 1'b1;
                end
                else if (!s.started && (c == CH_PLUS))
                begin
                    t.started = 1'b1;
                end
                else
                begin
                    t.started = 1'b1;
                    if ((c >= CH_ZERO) && (c <= CH_NINE))
                    begin
                        // saturate the magnitude at 2^31
                        if (prod > {4'd0, MAG_CAP})
                        begin
                            t.acc = MAG_CAP;
                        end
                        else
                        begin
                            t.acc = prod[31:0];
                        end
                    end
                    else
                    begin
                        t.digits_done = 1'b1;
                    end
                end
            end
        end
        return t;
    endfunction

    // Handshake and buffer control
    assign buf_busy   = (res_idx_reg < res_cnt_reg);
    assign out_fire   = m_tvalid && m_tready;
    assign buf_free   = !buf_busy
                     || (out_fire && ((res_idx_reg + RES_CNT_W'(1)) == res_cnt_reg));
    assign stage_move = in_valid_reg && buf_free;
    assign s_tready   = !in_valid_reg || stage_move;

    // Parse one registered byte: at most one field end, one byte, then a zero byte or the line-end closes the rest
    always_comb
    begin
        parse_state_t s;
        logic [7:0]   c;
        logic         blank;
        logic         quote;
        logic         fin;
        logic         do_byte;
        logic         early_end;
        logic         to_after;
        logic         run_after;
        logic         run_skip;
        logic         run_plain;
        logic [8:0]   lim;
        result_t      rb;

        s         = st_reg;
        c         = char_reg;
        blank     = (c == CH_SPACE) || (c == CH_TAB);
        quote     = (c == CH_QUOTE);
        fin       = 1'b0;
        do_byte   = 1'b0;
        early_end = 1'b0;
        to_after  = 1'b0;
        run_after = 1'b0;
        run_skip  = 1'b0;
        run_plain = 1'b0;
        lim       = 9'd0;
        rb        = '0;
        line_next = line_reg;
        res_cnt_next = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res_next[i] = '0;
        end

        if (({1'b0, line_reg} + (LINE_LEN_W + 1)'(1)) < LINE_LIM)
        begin
            line_next = line_reg + LINE_LEN_W'(1);
            if (s.phase != PH_DONE)
            begin
                if (c == CH_NUL)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    unique case (s.phase)
                        PH_SKIP:
                        begin
                            run_skip = 1'b1;
                        end
                        PH_PLAIN:
                        begin
                            run_plain = 1'b1;
                        end
                        PH_QUOTED:
                        begin
                            if (quote && slot_str(s))
                            begin
                                do_byte = 1'b1;
                                s.phase = PH_QSEEN;
                            end
                            else if (quote)
                            begin
                                early_end = 1'b1;
                                to_after  = 1'b1;
                            end
                            else
                            begin
                                do_byte = 1'b1;
                            end
                        end
                        PH_QSEEN:
                        begin
                            if (quote)
                            begin
                                do_byte = 1'b1;
                                s.phase = PH_QUOTED;
                            end
                            else
                            begin
                                early_end = 1'b1;
                                to_after  = 1'b1;
                                run_after = 1'b1;
                            end
                        end
                        PH_AFTER:
                        begin
                            run_after = 1'b1;
                        end
                        default:
                        begin
                            run_skip = 1'b0;
                        end
                    endcase

                    if (early_end)
                    begin
                        res_next[res_cnt_next] = end_result(s);
                        res_cnt_next           = res_cnt_next + RES_CNT_W'(1);
                        s                      = end_state(s);
                        if (s.phase == PH_DONE)
                        begin
                            run_after = 1'b0;
                        end
                        else if (to_after)
                        begin
                            s.phase = PH_AFTER;
                        end
                    end

                    if (run_after && !blank)
                    begin
                        s.phase  = PH_SKIP;
                        run_skip = (c != CH_COMMA);
                    end

                    if (run_skip && !blank)
                    begin
                        if (quote)
                        begin
                            do_byte = slot_str(s);
                            s.phase = PH_QUOTED;
                        end
                        else
                        begin
                            s.phase   = PH_PLAIN;
                            run_plain = 1'b1;
                        end
                    end

                    if (run_plain)
                    begin
                        if (c == CH_COMMA)
                        begin
                            res_next[res_cnt_next] = end_result(s);
                            res_cnt_next           = res_cnt_next + RES_CNT_W'(1);
                            s                      = end_state(s);
                        end
                        else
                        begin
                            do_byte = 1'b1;
                        end
                    end

                    if (do_byte)
                    begin
                        if (slot_str(s))
                        begin
                            lim = (s.pos == SLOT_NAME) ? NAME_LIM : KEY_LIM;
                            if (({1'b0, s.flen} + 9'd1) < lim)
                            begin
                                s.flen  = s.flen + 8'd1;
                                rb.kind = KIND_BYTE;
                                rb.slot = s.pos;
                                rb.ch   = c;
                                rb.num  = 32'd0;
                                rb.last = 1'b0;
                                res_next[res_cnt_next] = rb;
                                res_cnt_next           = res_cnt_next + RES_CNT_W'(1);
                            end
                        end
                        else
                        begin
                            s = number_byte(s, c);
                        end
                    end
                end
            end
        end

        if (eol_reg)
        begin
            fin = 1'b1;
        end

        // Close the open field and give the rest as empty or zero
        for (int i = 0; i < FIELD_MAX; i++)
        begin
            if (fin && (s.phase != PH_DONE))
            begin
                res_next[res_cnt_next] = end_result(s);
                res_cnt_next           = res_cnt_next + RES_CNT_W'(1);
                s                      = end_state(s);
            end
        end

        if (eol_reg)
        begin
            s         = clear_field(s);
            s.pos     = SLOT_NAME;
            s.phase   = PH_SKIP;
            line_next = '0;
        end

        st_next = s;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg <= s_tdata;
            eol_reg  <= s_tlast;
        end
    end

    // Parser state and result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= '{pos: SLOT_NAME, phase: PH_SKIP, flen: 8'd0, acc: 32'd0,
                             neg: 1'b0, digits_done: 1'b0, started: 1'b0, key_num: 1'b1};
            line_reg    <= '0;
            res_cnt_reg <= '0;
            res_idx_reg <= '0;
        end
        else if (stage_move)
        begin
            st_reg      <= st_next;
            line_reg    <= line_next;
            res_cnt_reg <= res_cnt_next;
            res_idx_reg <= '0;
        end
        else if (out_fire)
        begin
            res_idx_reg <= res_idx_reg + RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_move)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    assign cur_res  = res_reg[res_idx_reg];
    assign m_tvalid = buf_busy;
    assign m_tdata  = {cur_res.num, cur_res.ch};
    assign m_tuser  = {cur_res.slot, cur_res.kind};
    assign m_tlast  = cur_res.last;

endmodule

// ===== rtl/core/csvp_checker.sv =====
// Port-level checker for the CSV record field parser, bound to the top level.
`timescale 1ns / 1ps

module csvp_checker
    import csvp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled byte transaction stays offered and unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("input byte changed while stalled");

    // A stalled result transaction stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // String bytes carry no number
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == KIND_BYTE) |-> (m_tdata[39:8] == 32'd0))
        else $error("string byte with a number");

    // Field ends carry no character, and strings ends carry no number
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] != KIND_BYTE)
        |-> (m_tdata[7:0] == 8'd0)
            && ((m_tuser[1:0] == KIND_NUM_END) || (m_tdata[39:8] == 32'd0)))
        else $error("field end with stray payload");

    // Record end only on the close of the count field
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast
        |-> (m_tuser[3:2] == SLOT_COUNT) && (m_tuser[1:0] != KIND_BYTE))
        else $error("record end outside the count field end");

endmodule

bind csv_record_field_parser csvp_checker u_csvp_checker (.*);

// ===== test/csv_record_field_parser_tb.sv =====
// Self-checking testbench for the CSV record field parser: directed and random CSV lines, a field tokeniser model.
`timescale 1ns / 1ps

module csv_record_field_parser_tb;
    import csvp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 140;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } line_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;  // [7:0] char_in
    logic        s_tlast = 1'b0;   // end_of_line
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [7:0] char_value, [39:8] number_value
    logic [3:0]  m_tuser;          // [1:0] out_kind, [3:2] field_slot
    logic        m_tlast;          // last_of_record

    csv_record_field_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Tokeniser state, mirrored from the block's behaviour
    logic [1:0]  fpos = SLOT_NAME;
    scan_phase_t phase = PH_SKIP;
    int unsigned flen = 0;
    int unsigned line_len = 0;
    logic [31:0] mag = 32'd0;
    bit          neg = 1'b0;
    bit          digits_stop = 1'b0;
    bit          num_begun = 1'b0;
    bit          key_num = 1'b1;

    result_t     byte_tokens[$];   // tokens produced by the byte being modelled
    result_t     token_q[$];       // tokens still owed by the block
    line_char_t  pending_q[$];     // bytes waiting to be offered
    logic [7:0]  line_buf[$];      // line under construction

    line_char_t  cur_char;
    int          bytes_sent = 0;
    int          records_sent = 0;
    int          tokens_seen = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    int          hold_at = 0;
    int          ready_mode = 0;
    int          mode_left = 0;

    function automatic bit is_text_slot();
        return fpos == SLOT_NAME || (fpos == SLOT_KEY && !key_num);
    endfunction

    function automatic void put_token(out_kind_t k, logic [7:0] c, logic [31:0] n);
        result_t r;
        if (byte_tokens.size() >= MAX_RESULTS)
            return;
        r.kind = k;
        r.slot = fpos;
        r.ch   = c;
        r.num  = n;
        r.last = 1'b0;
        byte_tokens.push_back(r);
    endfunction

    function automatic void clear_field();
        flen        = 0;
        mag         = 32'd0;
        neg         = 1'b0;
        digits_stop = 1'b0;
        num_begun   = 1'b0;
    endfunction

    function automatic void take_text_char(logic [7:0] c);
        int unsigned lim;
        lim = (fpos == SLOT_NAME) ? NAME_MAX : KEY_MAX;
        if (flen + 1 < lim)
        begin
            flen++;
            put_token(KIND_BYTE, c, 32'd0);
        end
    endfunction

    // atoi-style accumulation; the magnitude sticks at 2^31 once it overflows
    function automatic void take_number_char(logic [7:0] c);
        logic [31:0] d;
        if (flen + 1 >= NUMBER_TEXT_MAX)
            return;
        flen++;
        if (digits_stop)
            return;
        if (!num_begun)
        begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                return;
            num_begun = 1'b1;
            if (c == CH_MINUS)
            begin
                neg = 1'b1;
                return;
            end
            if (c == CH_PLUS)
                return;
        end
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = 32'(c - CH_ZERO);
            if (mag > (MAG_CAP - d) / 32'd10)
                mag = MAG_CAP;
            else
                mag = mag * 32'd10 + d;
        end
        else
            digits_stop = 1'b1;
    endfunction

    function automatic void take_field_char(logic [7:0] c);
        if (is_text_slot())
            take_text_char(c);
        else
            take_number_char(c);
    endfunction

    function automatic void close_field();
        logic [31:0] m;
        logic [31:0] v;
        result_t     r;
        if (is_text_slot())
            put_token(KIND_STR_END, 8'h00, 32'd0);
        else
        begin
            m = mag;
            if (neg)
            begin
                if (m > MAG_CAP)
                    m = MAG_CAP;
                v = 32'd0 - m;
            end
            else
            begin
                if (m > MAG_CAP - 32'd1)
                    m = MAG_CAP - 32'd1;
                v = m;
            end
            if (fpos == SLOT_KEY_TYPE)
                key_num = (v == 32'd0);
            put_token(KIND_NUM_END, 8'h00, v);
        end
        clear_field();
        if (fpos == SLOT_COUNT)
        begin
            if (byte_tokens.size() > 0)
            begin
                r = byte_tokens.pop_back();
                r.last = 1'b1;
                byte_tokens.push_back(r);
            end
            phase = PH_DONE;
        end
        else
        begin
            fpos++;
            phase = PH_SKIP;
        end
    endfunction

    function automatic void close_record();
        while (phase != PH_DONE)
            close_field();
    endfunction

    function automatic void parse_char(logic [7:0] c);
        bit blank;
        bit again;
        blank = (c == CH_SPACE || c == CH_TAB);
        if (phase == PH_DONE)
            return;
        if (c == CH_NUL)
        begin
            close_record();
            return;
        end
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (phase)
                PH_SKIP:
                    if (!blank)
                    begin
                        if (c == CH_QUOTE)
                        begin
                            if (is_text_slot())
                                take_text_char(c);
                            phase = PH_QUOTED;
                        end
                        else
                        begin
                            phase = PH_PLAIN;
                            again = 1'b1;
                        end
                    end
                PH_PLAIN:
                    if (c == CH_COMMA)
                        close_field();
                    else
                        take_field_char(c);
                PH_QUOTED:
                    if (c == CH_QUOTE)
                    begin
                        if (is_text_slot())
                        begin
                            take_text_char(c);
                            phase = PH_QSEEN;
                        end
                        else
                        begin
                            // quoted number ends at its closing quote
                            close_field();
                            if (phase != PH_DONE)
                                phase = PH_AFTER;
                        end
                    end
                    else
                        take_field_char(c);
                PH_QSEEN:
                    if (c == CH_QUOTE)
                    begin
                        take_text_char(c);
                        phase = PH_QUOTED;
                    end
                    else
                    begin
                        close_field();
                        if (phase != PH_DONE)
                        begin
                            phase = PH_AFTER;
                            again = 1'b1;
                        end
                    end
                PH_AFTER:
                    if (!blank)
                    begin
                        phase = PH_SKIP;
                        if (c != CH_COMMA)
                            again = 1'b1;
                    end
                default: ;
            endcase
        end
    endfunction

    function automatic void tokenise_char(line_char_t lc);
        byte_tokens.delete();
        // bytes past the line limit are dropped, but their end mark still counts
        if (line_len + 1 < LINE_MAX)
        begin
            line_len++;
            parse_char(lc.ch);
        end
        if (lc.eol)
        begin
            close_record();
            fpos     = SLOT_NAME;
            phase    = PH_SKIP;
            line_len = 0;
            clear_field();
        end
        foreach (byte_tokens[i])
            token_q.push_back(byte_tokens[i]);
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void add_blanks();
        repeat ($urandom_range(0, 2))
            line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_COMMA || c == CH_QUOTE);
        return c;
    endfunction

    function automatic void add_text_field();
        logic [7:0] c;
        case ($urandom_range(0, 15))
            0, 1: ;
            2, 3, 4, 5, 6, 7:
                repeat ($urandom_range(1, 6))
                    line_buf.push_back(plain_char());
            8, 9, 10, 11, 12, 13, 14:
            begin
                line_buf.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 6))
                begin
                    c = 8'($urandom_range(1, 255));
                    if (c == CH_QUOTE || $urandom_range(0, 5) == 0)
                    begin
                        line_buf.push_back(CH_QUOTE);
                        line_buf.push_back(CH_QUOTE);
                    end
                    else
                        line_buf.push_back(c);
                end
                line_buf.push_back(CH_QUOTE);
            end
            default:
                // 60 to 70 bytes, often long enough to be truncated
                repeat ($urandom_range(60, 70))
                    line_buf.push_back(plain_char());
        endcase
    endfunction

    function automatic string number_text(bit zero_like);
        string s;
        string sign;
        s = "";
        case ($urandom_range(0, 3))
            0:       sign = "-";
            1:       sign = "+";
            default: sign = "";
        endcase
        if (zero_like)
        begin
            case ($urandom_range(0, 3))
                0: s = "0";
                1: s = "000";
                2: s = "";
                default: s = "x7";
            endcase
        end
        else
        begin
            case ($urandom_range(0, 7))
                0, 1, 2: s = $sformatf("%0d", $urandom_range(1, 999));
                3: s = $sformatf("%0d", $urandom);
                4: s = "2147483647";
                5: s = "2147483648";
                6: s = $sformatf("%0d%0d", $urandom_range(1, 9), $urandom);
                default:
                begin
                    repeat (62) s = {s, "0"};
                    s = {s, $sformatf("%0d", $urandom_range(10, 99))};
                end
            endcase
        end
        if ($urandom_range(0, 6) == 0)
            s = {s, $urandom_range(0, 1) ? "z9" : " 4"};
        s = {sign, s};
        if ($urandom_range(0, 4) == 0)
            s = {"\"", s, "\""};
        return s;
    endfunction

    function automatic void add_record();
        bit key_type_zero;
        key_type_zero = $urandom_range(0, 1);
        add_blanks();
        add_text_field();
        add_blanks();
        line_buf.push_back(CH_COMMA);
        add_blanks();
        add_text(number_text(key_type_zero));
        add_blanks();
        line_buf.push_back(CH_COMMA);
        add_blanks();
        if (key_type_zero)
            add_text(number_text($urandom_range(0, 3) == 0));
        else
            add_text_field();
        add_blanks();
        line_buf.push_back(CH_COMMA);
        add_blanks();
        add_text(number_text($urandom_range(0, 3) == 0));
        if ($urandom_range(0, 4) == 0)
            add_text(",tail,9");
    endfunction

    function automatic void send_line();
        line_char_t lc;
        if (line_buf.size() == 0)
            line_buf.push_back(CH_SPACE);
        foreach (line_buf[i])
        begin
            lc.ch  = line_buf[i];
            lc.eol = (i == line_buf.size() - 1);
            pending_q.push_back(lc);
        end
        line_buf.delete();
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || s_tvalid || token_q.size() != 0);
    endtask

    // ---------------- byte driver ----------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                tokenise_char(cur_char);
                bytes_sent++;
                if (cur_char.eol)
                    records_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                // keep offering while the output is held off, so the input backs up
                if (gap_left != 0 && hold_left == 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    cur_char = pending_q.pop_front();
                    s_tdata  <= cur_char.ch;
                    s_tlast  <= cur_char.eol;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- output back-pressure ----------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_at != 0 && bytes_sent >= hold_at)
            begin
                hold_at   = 0;
                hold_left = 400;
                m_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    ready_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(8, 80);
                end
                else
                    mode_left--;
                case (ready_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ---------------- token monitor ----------------

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = out_kind_t'(m_tuser[1:0]);
            got.slot = m_tuser[3:2];
            got.ch   = m_tdata[7:0];
            got.num  = m_tdata[39:8];
            got.last = m_tlast;
            tokens_seen++;
            if (token_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected token kind %0d slot %0d char %02h num %0d last %0b",
                         $time, got.kind, got.slot, got.ch, $signed(got.num), got.last);
            end
            else
            begin
                want = token_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    $display("%0t: token %0d expected kind %0d slot %0d char %02h num %0d last %0b",
                             $time, tokens_seen, want.kind, want.slot, want.ch,
                             $signed(want.num), want.last);
                    $display("%0t: token %0d actual   kind %0d slot %0d char %02h num %0d last %0b",
                             $time, tokens_seen, got.kind, got.slot, got.ch,
                             $signed(got.num), got.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d tokens outstanding",
                     cycle_count, token_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- test sequence ----------------

    initial
    begin
        int pick;
        int cut;
        int random_bytes;
        random_bytes = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // doubled quotes in a quoted name, quoted number key, junk after the count
        add_text("\"q\"\"\",0,\"-7\"x ,-");
        send_line();
        // empty name from blanks, string key, line ends before the count
        add_text(" \t,5,k");
        send_line();
        // zero byte alone
        line_buf.push_back(CH_NUL);
        send_line();
        // negative zero key type, saturation both ways, bytes after a full record
        add_text("9,-0,2147483648,-99999999999,x");
        send_line();
        // top-bit bytes, then a zero byte in the key and a byte it hides
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h80);
        add_text(",1,");
        line_buf.push_back(CH_NUL);
        add_text("z");
        send_line();

        // let everything drain before the random traffic
        wait_drained();
        hold_at = bytes_sent + 40;

        while (random_bytes < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 2)
            begin
                repeat ($urandom_range(1, 16))
                begin
                    case ($urandom_range(0, 3))
                        0:       line_buf.push_back(CH_COMMA);
                        1:       line_buf.push_back(CH_QUOTE);
                        default: line_buf.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            else
            begin
                add_record();
                if (pick == 2)
                begin
                    cut = $urandom_range(1, line_buf.size());
                    while (line_buf.size() > cut)
                        void'(line_buf.pop_back());
                end
                else if (pick == 3)
                    line_buf.insert($urandom_range(0, line_buf.size() - 1), CH_NUL);
            end
            random_bytes += line_buf.size();
            send_line();
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (token_q.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d tokens never arrived", $time, token_q.size());
        end
        $display("Sent %0d bytes in %0d lines; checked %0d tokens, %0d mismatches",
                 bytes_sent, records_sent, tokens_seen, mismatches);
        $display("Lines covered quoting, saturation, early ends, zero bytes and a long stall");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/csvp_pkg.sv
rtl/core/csv_record_field_parser.sv
rtl/core/csvp_checker.sv
test/csv_record_field_parser_tb.sv
